[rtl/mtet_pkg.sv]
// ----------------------------------------------------------------------------
// mtet_pkg
// Shared types and constants for the multi-turn encoder tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package mtet_pkg;

	localparam int SAMPLE_W = 17;   // input sample / reference angle width
	localparam int STEP_W   = 18;   // stored step width
	localparam int CPT_W    = 17;   // counts-per-turn register width
	localparam int TURNS_W  = 32;   // turn counter width
	localparam int OUT_TOT_W = 32;  // exported total width

	localparam logic [CPT_W-1:0] CPT_RESET = CPT_W'(4096);
	localparam logic [CPT_W-1:0] CPT_MIN   = CPT_W'(2);

	// configuration register indexes
	localparam logic CFG_KIND = 1'b0;
	localparam logic CFG_CPT  = 1'b1;

	// encoder kinds
	localparam logic KIND_ABS = 1'b0;
	localparam logic KIND_INC = 1'b1;

	// item modes
	localparam logic MODE_UPDATE = 1'b0;
	localparam logic MODE_SEED   = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIFF,
		ST_FOLD,
		ST_ACC,
		ST_DSTART,
		ST_DIV,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_status_t;

endpackage

`default_nettype wire

[rtl/mtet_div.sv]
// ----------------------------------------------------------------------------
// mtet_div
// Radix-2 restoring signed divider, one quotient bit per cycle.
// Quotient and remainder truncate toward zero.
// ----------------------------------------------------------------------------
`default_nettype none

module mtet_div #(
	parameter int DW = 32,
	parameter int VW = 17
) (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        start,
	input  wire logic signed [DW-1:0]  dividend,
	input  wire logic        [VW-1:0]  divisor,   // nonzero, positive
	output mtet_pkg::div_status_t      stat,
	output logic signed      [DW-1:0]  quotient,
	output logic signed      [VW:0]    remainder
);
	import mtet_pkg::*;

	localparam int CNT_W = $clog2(DW);
	localparam logic [CNT_W-1:0] LAST = CNT_W'(DW - 1);

	logic [DW-1:0]    quo_q;
	logic [VW-1:0]    rem_q;
	logic [VW-1:0]    dvs_q;
	logic             neg_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [VW:0]      shifted;
	logic [VW:0]      trial;
	logic [DW-1:0]    mag;

	assign mag     = dividend[DW-1] ? (~dividend + DW'(1)) : dividend;
	assign shifted = {rem_q, quo_q[DW-1]};
	assign trial   = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// payload, no reset
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= mag;
			rem_q <= '0;
			dvs_q <= divisor;
			neg_q <= dividend[DW-1];
		end else if (busy_q) begin
			if (!trial[VW]) begin
				rem_q <= trial[VW-1:0];
				quo_q <= {quo_q[DW-2:0], 1'b1};
			end else begin
				rem_q <= shifted[VW-1:0];
				quo_q <= {quo_q[DW-2:0], 1'b0};
			end
		end
	end

	assign quotient  = neg_q ? -$signed(quo_q) : $signed(quo_q);
	assign remainder = neg_q ? -$signed({1'b0, rem_q}) : $signed({1'b0, rem_q});

	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

`default_nettype wire

[rtl/multi_turn_encoder_tracker.sv]
// ----------------------------------------------------------------------------
// multi_turn_encoder_tracker
// Unwraps a rotary encoder position across turns, absolute or incremental.
// ----------------------------------------------------------------------------
// Sequence: a seed goes straight to the result register; an absolute update
//   steps through difference, fold and accumulate; an incremental one
//   accumulates and then runs the radix-2 divider, one quotient bit per
//   cycle over TOTAL_WIDTH bits. The next item is taken only once the result
//   is loaded, which waits out any output stall.
// Reset: asynchronous, active low; absolute kind, 4096 counts per turn,
//   reference unset (-1), totals and turns cleared. No clearing pass.
`default_nettype none

module multi_turn_encoder_tracker #(
	parameter int ANGLE_WIDTH = 16,   // 8..24, turn size clamps at 2^ANGLE_WIDTH
	parameter int TOTAL_WIDTH = 32    // 16..64, accumulator width
) (
	input  wire          clk,
	input  wire          arst_n,
	// input stream
	input  wire          s_tvalid,
	output logic         s_tready,
	input  wire  [23:0]  s_tdata,   // [16:0] sample (signed), zero pad
	input  wire  [0:0]   s_tuser,   // [0] mode
	// result stream
	output logic         m_tvalid,
	input  wire          m_tready,
	output logic [103:0] m_tdata,   // [16:0] angle_in_turn, [48:17] angle_total,
	                                // [66:49] last_step, [98:67] turn_count, pad
	// configuration writes
	input  wire          cfg_valid,
	output logic         cfg_ready,
	input  wire  [0:0]   cfg_index,
	input  wire  [16:0]  cfg_data
);
	import mtet_pkg::*;

	// Turn-size clamp is compared at a width that holds both the register
	// and 2^ANGLE_WIDTH.
	localparam int CW = (ANGLE_WIDTH + 1 > CPT_W) ? ANGLE_WIDTH + 1 : CPT_W;
	localparam logic [CW-1:0] TSZ_MAX = CW'(1) << ANGLE_WIDTH;

	// ---------------------------------------------------------------- state
	state_t state_q, state_d;

	logic                       kind_q;
	logic        [CPT_W-1:0]    cpt_q;      // clamped turn size
	logic signed [SAMPLE_W-1:0] ref_q;      // reference angle / angle in turn
	logic signed [TOTAL_WIDTH-1:0] total_q;
	logic signed [STEP_W-1:0]   step_q;
	logic signed [TURNS_W-1:0]  turns_q;

	// accepted item
	logic                       mode_q;
	logic signed [SAMPLE_W-1:0] sample_q;

	// absolute path intermediate
	logic signed [STEP_W-1:0]   diff_q;

	// ----------------------------------------------------- handshakes / ctl
	logic in_xact;
	logic cfg_xact;
	logic div_start;
	logic out_load;

	assign cfg_ready = 1'b1;   // writes must only arrive while idle; the block itself does not enforce it
	assign in_xact   = s_tvalid && s_tready;
	assign cfg_xact  = cfg_valid && cfg_ready;

	// ------------------------------------------------------------- divider
	div_status_t                      div_stat;
	logic signed [TOTAL_WIDTH-1:0]    div_quo;
	logic signed [CPT_W:0]            div_rem;

	mtet_div #(
		.DW(TOTAL_WIDTH),
		.VW(CPT_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (total_q),
		.divisor  (cpt_q),
		.stat     (div_stat),
		.quotient (div_quo),
		.remainder(div_rem)
	);

	// ----------------------------------------------------- config clamping
	logic [CPT_W-1:0] cpt_new;

	always_comb begin
		priority if (cfg_data < CPT_MIN) begin
			cpt_new = CPT_MIN;
		end else if (CW'(cfg_data) > TSZ_MAX) begin
			cpt_new = CPT_W'(TSZ_MAX);
		end else begin
			cpt_new = cfg_data;
		end
	end

	// ---------------------------------------------------------- fold logic
	// Step beyond half a turn folds by one turn and moves the turn count.
	logic signed [STEP_W:0] diff_x;
	logic signed [STEP_W:0] half_x;
	logic signed [STEP_W:0] cpt_x;
	logic signed [STEP_W:0] fold_d;
	logic                   fold_dn;
	logic                   fold_up;

	assign diff_x  = {diff_q[STEP_W-1], diff_q};
	assign half_x  = $signed({3'b000, cpt_q[CPT_W-1:1]});
	assign cpt_x   = $signed({2'b00, cpt_q});
	assign fold_dn = diff_x > half_x;
	assign fold_up = diff_x < -half_x;

	always_comb begin
		priority if (fold_dn) begin
			fold_d = diff_x - cpt_x;
		end else if (fold_up) begin
			fold_d = diff_x + cpt_x;
		end else begin
			fold_d = diff_x;
		end
	end

	// ------------------------------------------------------ sequencer: next
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_xact) begin
					priority if (s_tuser[0] == MODE_SEED) begin
						state_d = ST_DONE;
					end else if (kind_q == KIND_ABS) begin
						state_d = ST_DIFF;
					end else begin
						state_d = ST_ACC;
					end
				end
			end
			ST_DIFF:   state_d = ST_FOLD;
			ST_FOLD:   state_d = ST_ACC;
			ST_ACC:    state_d = (kind_q == KIND_ABS) ? ST_DONE : ST_DSTART;
			ST_DSTART: state_d = ST_DIV;
			ST_DIV:    state_d = div_stat.done ? ST_DONE : ST_DIV;
			ST_DONE:   state_d = (!m_tvalid || m_tready) ? ST_IDLE : ST_DONE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// --------------------------------------------------- sequencer: outputs
	always_comb begin
		s_tready  = 1'b0;
		div_start = 1'b0;
		out_load  = 1'b0;
		unique case (state_q)
			ST_IDLE:   s_tready  = 1'b1;
			ST_DSTART: div_start = 1'b1;
			ST_DONE:   out_load  = !m_tvalid || m_tready;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// ------------------------------------------------------ tracking state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q  <= KIND_ABS;
			cpt_q   <= CPT_RESET;
			ref_q   <= -SAMPLE_W'(1);
			total_q <= '0;
			step_q  <= '0;
			turns_q <= '0;
		end else if (cfg_xact) begin
			// any register write restarts tracking under the new settings
			unique case (cfg_index[0])
				CFG_KIND: begin
					kind_q <= cfg_data[0];
					ref_q  <= (cfg_data[0] == KIND_ABS) ? -SAMPLE_W'(1) : '0;
				end
				CFG_CPT: begin
					cpt_q <= cpt_new;
					ref_q <= (kind_q == KIND_ABS) ? -SAMPLE_W'(1) : '0;
				end
			endcase
			total_q <= '0;
			step_q  <= '0;
			turns_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_xact) begin
						if (s_tuser[0] == MODE_SEED) begin
							// seed only while the reference is unset (negative), only for absolute encoders
							if (kind_q == KIND_ABS && ref_q[SAMPLE_W-1]) begin
								ref_q <= $signed(s_tdata[SAMPLE_W-1:0]);
							end
						end else if (kind_q == KIND_INC) begin
							step_q <= STEP_W'($signed(s_tdata[SAMPLE_W-1:0]));
						end
					end
				end
				ST_FOLD: begin
					step_q <= fold_d[STEP_W-1:0];
					ref_q  <= sample_q;
					if (fold_dn) begin
						turns_q <= turns_q - TURNS_W'(1);
					end else if (fold_up) begin
						turns_q <= turns_q + TURNS_W'(1);
					end
				end
				ST_ACC: begin
					total_q <= total_q + TOTAL_WIDTH'(step_q);
				end
				ST_DIV: begin
					if (div_stat.done) begin
						turns_q <= TURNS_W'(div_quo);
						ref_q   <= div_rem[SAMPLE_W-1:0];
					end
				end
				default: begin
				end
			endcase
		end
	end

	// item capture and step difference (payload, no reset)
	always_ff @(posedge clk) begin
		if (in_xact) begin
			mode_q   <= s_tuser[0];
			sample_q <= $signed(s_tdata[SAMPLE_W-1:0]);
		end
		if (state_q == ST_DIFF) begin
			diff_q <= STEP_W'(sample_q) - STEP_W'(ref_q);
		end
	end

	// ------------------------------------------------------ result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (out_load) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata <= {5'b00000, turns_q, step_q, OUT_TOT_W'(total_q), ref_q};
		end
	end

	// ---------------------------------------------------------- assertions
	// Divider completion only lands while the sequencer waits on it.
	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> state_q == ST_DIV)
		else $error("divider finished outside the divide wait");

	// No new transaction while the divider is running.
	a_busy_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.busy |-> !s_tready)
		else $error("input ready while divider busy");

	// An accepted item holds off the next one: input ready is low in the following cycle.
	a_accept_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		in_xact |=> !s_tready)
		else $error("back-to-back input accepted");

	// An update in absolute mode walks through the fold step.
	a_abs_fold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIFF) |=> (state_q == ST_FOLD) && (mode_q == MODE_UPDATE))
		else $error("absolute update skipped the fold step");

endmodule

`default_nettype wire

[test/multi_turn_encoder_tracker_tb.sv]
// ----------------------------------------------------------------------------
// multi_turn_encoder_tracker_tb
// Self-checking bench for the multi-turn encoder tracker. Items are fed over
// the input stream under random source gaps and sink stalls. Each accepted
// item runs through a local tracker model, and the results are compared
// field by field in arrival order. Directed cases cover reset state, seeding,
// turn folding at the half-turn limits, turn size clamping and incremental
// truncation. They are followed by random traffic over many configurations.
// ----------------------------------------------------------------------------
module multi_turn_encoder_tracker_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import mtet_pkg::*;

	localparam int     WATCHDOG_LIMIT = 3000;   // cycles with no transaction at all
	localparam int     DRAIN_CYCLES   = 45;     // covers the longest (incremental) path
	localparam int     SEGMENTS       = 10;     // segments per phase, each under a new configuration
	localparam int     SEGMENT_ITEMS  = 28;
	localparam longint SPAN_MAX       = 65536;  // 2^ANGLE_WIDTH at the default

	logic         clk;
	logic         arst_n    = 1'b0;
	logic         s_tvalid  = 1'b0;
	logic         s_tready;
	logic [23:0]  s_tdata   = '0;   // [16:0] sample, zero pad
	logic [0:0]   s_tuser   = '0;   // [0] mode
	logic         m_tvalid;
	logic         m_tready  = 1'b0;
	logic [103:0] m_tdata;          // [16:0] angle, [48:17] total, [66:49] step,
	                                // [98:67] turns, zero pad
	logic         cfg_valid = 1'b0;
	logic         cfg_ready;
	logic [0:0]   cfg_index = '0;
	logic [16:0]  cfg_data  = '0;

	typedef struct {
		longint angle;
		longint total;
		longint step;
		longint turns;
	} track_result_t;

	track_result_t pending_results[$];
	track_result_t oldest_result;

	// tracker model state
	logic         cur_kind;
	logic [16:0]  cur_cpt;
	longint       pos_ref;
	longint       acc_total;
	longint       last_delta;
	longint       turn_ctr;

	int           src_idle_pct   = 0;
	int           sink_stall_pct = 0;
	int           mismatches     = 0;
	int           quiet_cycles   = 0;

	multi_turn_encoder_tracker i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// Tracker model
	// ------------------------------------------------------------------------

	// two's complement wrap of v to w bits
	function automatic longint sext(input longint v, input int w);
		return (v <<< (64 - w)) >>> (64 - w);
	endfunction

	// effective counts per turn after clamping
	function automatic longint turn_span();
		if (cur_cpt < 2)
			return 2;
		if (longint'(cur_cpt) > SPAN_MAX)
			return SPAN_MAX;
		return longint'(cur_cpt);
	endfunction

	// any register write restarts tracking with the new settings
	task automatic clear_tracker();
		pos_ref    = (cur_kind == KIND_ABS) ? -1 : 0;
		acc_total  = 0;
		last_delta = 0;
		turn_ctr   = 0;
	endtask

	task automatic track_item(input logic mode, input logic signed [16:0] smp);
		longint s;
		longint span;
		longint d;
		track_result_t r;
		s    = smp;
		span = turn_span();
		if (mode == MODE_SEED) begin
			// only an absolute encoder with no reference yet takes a seed
			if (cur_kind == KIND_ABS && pos_ref < 0)
				pos_ref = s;
		end else if (cur_kind == KIND_ABS) begin
			d = s - pos_ref;
			if (d > span / 2) begin
				d -= span;
				turn_ctr = sext(turn_ctr - 1, 32);
			end else if (d < -(span / 2)) begin
				d += span;
				turn_ctr = sext(turn_ctr + 1, 32);
			end
			last_delta = sext(d, 18);
			pos_ref    = s;
			acc_total  = sext(acc_total + last_delta, 32);
		end else begin
			// incremental: SV division truncates toward zero, remainder follows dividend
			last_delta = s;
			acc_total  = sext(acc_total + last_delta, 32);
			turn_ctr   = sext(acc_total / span, 32);
			pos_ref    = sext(acc_total % span, 17);
		end
		r = '{pos_ref, acc_total, last_delta, turn_ctr};
		pending_results.push_back(r);
	endtask

	// ------------------------------------------------------------------------
	// Stream and configuration drivers
	// ------------------------------------------------------------------------

	// tvalid is left high after a transaction; the next call either replaces
	// the data in the same step or drops tvalid for a gap
	task automatic send_item(input logic mode, input logic signed [16:0] smp);
		if ($urandom_range(99, 0) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99, 0) < src_idle_pct);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {7'b0, smp};
		s_tuser  <= mode;
		do
			@(posedge clk);
		while (!(s_tvalid && s_tready));
		track_item(mode, smp);
	endtask

	task automatic wait_for_results();
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// writes only once every result is out; keep_valid holds cfg_valid for a
	// write that follows directly
	task automatic write_reg(input logic [0:0] idx, input logic [16:0] val,
	                         input bit keep_valid = 1'b0);
		s_tvalid <= 1'b0;
		wait_for_results();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do
			@(posedge clk);
		while (!(cfg_valid && cfg_ready));
		if (!keep_valid)
			cfg_valid <= 1'b0;
		if (idx == CFG_KIND)
			cur_kind = val[0];
		else
			cur_cpt = val;
		clear_tracker();
	endtask

	// ------------------------------------------------------------------------
	// Result checking and sink backpressure
	// ------------------------------------------------------------------------

	task automatic check_field(input string name, input longint want, input longint got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				$error("result transaction with nothing pending");
				mismatches++;
			end else begin
				oldest_result = pending_results.pop_front();
				check_field("angle_in_turn", oldest_result.angle, $signed(m_tdata[16:0]));
				check_field("angle_total", oldest_result.total, $signed(m_tdata[48:17]));
				check_field("last_step", oldest_result.step, $signed(m_tdata[66:49]));
				check_field("turn_count", oldest_result.turns, $signed(m_tdata[98:67]));
			end
		end
		m_tready <= ($urandom_range(99, 0) >= sink_stall_pct);
	end

	// any accepted transaction on any channel resets the count
	initial begin
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)
			    || (cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("multi_turn_encoder_tracker: mismatch");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// reset state, seeding rules and folding at exactly half a turn
	task automatic test_absolute_unwrap();
		// update straight out of reset steps from the unset reference
		send_item(MODE_UPDATE, 17'sd10);
		send_item(MODE_SEED, 17'sd7);         // reference already set: ignored
		write_reg(CFG_CPT, CPT_RESET);
		send_item(MODE_SEED, -17'sd5);        // negative seed leaves it unset
		send_item(MODE_SEED, 17'sd100);
		send_item(MODE_SEED, 17'sd200);       // second seed ignored
		send_item(MODE_UPDATE, 17'sd4000);    // wraps backward, turn down
		send_item(MODE_UPDATE, 17'sd50);      // wraps forward, turn up
		send_item(MODE_UPDATE, 17'sd2148);    // just past half a turn
		send_item(MODE_UPDATE, 17'sd100);     // exactly minus half: no fold
		send_item(MODE_UPDATE, 17'sd2148);    // exactly half: no fold
		send_item(MODE_UPDATE, 17'h0FFFF);    // sample extremes
		send_item(MODE_UPDATE, 17'h10000);
	endtask

	// turn size below 2 and above 2^16 clamp
	task automatic test_turn_size_clamp();
		write_reg(CFG_CPT, 17'd0);
		send_item(MODE_SEED, 17'sd0);
		send_item(MODE_UPDATE, 17'sd1);
		send_item(MODE_UPDATE, 17'sd0);
		write_reg(CFG_CPT, 17'h1FFFF);
		send_item(MODE_SEED, 17'sd0);
		send_item(MODE_UPDATE, 17'sd32768);
		send_item(MODE_UPDATE, 17'sd65535);
		send_item(MODE_UPDATE, 17'sd0);
	endtask

	// deltas, ignored seed, negative totals with truncating division
	task automatic test_incremental();
		write_reg(CFG_KIND, KIND_INC);
		send_item(MODE_SEED, 17'sd5);
		send_item(MODE_UPDATE, 17'h0FFFF);
		send_item(MODE_UPDATE, 17'sd1);       // lands on a whole turn
		send_item(MODE_UPDATE, 17'h10000);
		send_item(MODE_UPDATE, 17'h10000);
		send_item(MODE_UPDATE, -17'sd3);
		write_reg(CFG_CPT, 17'd3);
		send_item(MODE_UPDATE, -17'sd7);
		send_item(MODE_UPDATE, 17'sd0);
	endtask

	// mostly well-formed motion with random content, plus raw samples and seeds
	task automatic run_segment(input int n_items);
		longint span;
		longint pos;
		longint delta;
		int     pick;
		span = turn_span();
		pos  = $urandom_range(int'(span - 1), 0);
		if (cur_kind == KIND_ABS)
			send_item(MODE_SEED, 17'(pos));
		for (int i = 1; i < n_items; i++) begin
			pick = $urandom_range(99, 0);
			if (cur_kind == KIND_ABS && pick < 78) begin
				if ($urandom_range(1, 0))
					delta = longint'($urandom_range(16, 0)) - 8;
				else
					delta = longint'($urandom_range(int'(span - 1), 0)) - span / 2;
				pos = ((pos + delta) % span + span) % span;
				send_item(MODE_UPDATE, 17'(pos));
			end else if (cur_kind == KIND_INC && pick < 45) begin
				delta = longint'($urandom_range(int'(2 * span), 0)) - span;
				send_item(MODE_UPDATE, 17'(delta));
			end else if (pick < 90) begin
				send_item(MODE_UPDATE, 17'($urandom));
			end else begin
				send_item(MODE_SEED, 17'($urandom));
			end
		end
	endtask

	task automatic test_random_traffic();
		int          src_pct[4]  = '{0, 79, 0, 10};
		int          sink_pct[4] = '{0, 0, 79, 10};
		logic [16:0] cpt;
		for (int ph = 0; ph < 4; ph++) begin
			src_idle_pct   = src_pct[ph];
			sink_stall_pct = sink_pct[ph];
			for (int seg = 0; seg < SEGMENTS; seg++) begin
				case ($urandom_range(5, 0))
					0: cpt = 17'($urandom_range(16, 2));
					1: cpt = CPT_RESET;
					2: cpt = 17'(SPAN_MAX);
					3: cpt = 17'($urandom_range(65536, 2));
					4: cpt = 17'($urandom_range(1, 0));
					default: cpt = 17'($urandom_range(131071, 65537));
				endcase
				write_reg(CFG_KIND, $urandom_range(1, 0) ? KIND_INC : KIND_ABS, 1'b1);
				write_reg(CFG_CPT, cpt);
				run_segment(SEGMENT_ITEMS);
			end
		end
	endtask

	initial begin
		cur_kind = KIND_ABS;
		cur_cpt  = CPT_RESET;
		clear_tracker();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		test_absolute_unwrap();
		test_turn_size_clamp();
		test_incremental();
		test_random_traffic();

		s_tvalid <= 1'b0;
		wait_for_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("multi_turn_encoder_tracker: match");
		else
			$display("multi_turn_encoder_tracker: mismatch");
		$finish;
	end

endmodule

[sim.f]
rtl/mtet_pkg.sv
rtl/mtet_div.sv
rtl/multi_turn_encoder_tracker.sv
test/multi_turn_encoder_tracker_tb.sv
